// ----- rtl/sitra_pkg.sv -----
// Shared constants, types and helpers for the signed integer to radix text converter.
package sitra_pkg;

  localparam int WORD_BITS   = 32;
  localparam int STORE_DEPTH = WORD_BITS + 1;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int BIT_CNT_W   = $clog2(WORD_BITS);
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(WORD_BITS - 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;  // '-'
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic div_step;
    logic rd_issue;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic last_bit;
    logic quot_zero_nxt;
    logic neg;
    logic idx_zero;
    logic out_free;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

// ----- rtl/sitra_if.sv -----
// Valid/ready channel interfaces for input integers and output characters.
interface sitra_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [sitra_pkg::WORD_BITS-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitra_out_if;
  logic                             valid;
  logic                             ready;
  logic [sitra_pkg::CHAR_W-1:0]     char_code;
  logic                             last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- rtl/sitra_ctrl.sv -----
// Controller state machine: sequences division, digit readback and character output.
module sitra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sitra_pkg::status_t  status,
  output sitra_pkg::cmd_t     cmd
);

  sitra_pkg::state_t state_r;
  sitra_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sitra_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      sitra_pkg::ST_IDLE: begin
        // hold off the input while reset is applied
        cmd.in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = sitra_pkg::ST_DIV;
        end
      end
      sitra_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        // last bit of a division: digit is stored, stop once the quotient is gone
        if (status.last_bit && status.quot_zero_nxt) begin
          state_nxt = status.neg ? sitra_pkg::ST_SIGN : sitra_pkg::ST_FETCH;
        end
      end
      sitra_pkg::ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = sitra_pkg::ST_FETCH;
        end
      end
      sitra_pkg::ST_FETCH: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = sitra_pkg::ST_EMIT;
      end
      sitra_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          state_nxt      = status.idx_zero ? sitra_pkg::ST_IDLE : sitra_pkg::ST_FETCH;
        end
      end
      default: begin
        state_nxt = sitra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/sitra_dp.sv -----
// Datapath: radix register, bit-serial divider, digit store and output word register.
module sitra_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  sitra_pkg::cmd_t                         cmd,
  output sitra_pkg::status_t                      status,
  input  logic                                    cfg_we,
  input  logic [sitra_pkg::RADIX_W-1:0]           cfg_data,
  input  logic signed [sitra_pkg::WORD_BITS-1:0]  in_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [sitra_pkg::CHAR_W-1:0]            out_char_code,
  output logic                                    out_last
);

  localparam int W = sitra_pkg::WORD_BITS;
  localparam int DW = sitra_pkg::DIGIT_W;

  logic [sitra_pkg::RADIX_W-1:0]   radix_r;
  logic [sitra_pkg::RADIX_W-1:0]   base;
  logic [W-1:0]                    mag_r, mag_nxt;
  logic [DW-1:0]                   rem_r, rem_nxt;
  logic [DW:0]                     trial;
  logic                            trial_ge;
  logic [sitra_pkg::BIT_CNT_W-1:0] bit_cnt_r;
  logic [sitra_pkg::IDX_W-1:0]     count_r;
  logic [sitra_pkg::IDX_W-1:0]     idx_r;
  logic                            neg_r;
  logic [DW-1:0]                   digit_store [sitra_pkg::STORE_DEPTH];
  logic [DW-1:0]                   rd_data_r;
  logic                            out_valid_r;
  logic [sitra_pkg::CHAR_W-1:0]    char_r;
  logic                            last_r;

  always_comb begin
    if (radix_r < sitra_pkg::RADIX_MIN) begin
      base = sitra_pkg::RADIX_MIN;
    end else if (radix_r > sitra_pkg::RADIX_MAX) begin
      base = sitra_pkg::RADIX_MAX;
    end else begin
      base = radix_r;
    end
  end

  // restoring division step: shift one quotient bit in per cycle
  always_comb begin
    trial    = {rem_r, mag_r[W-1]};
    trial_ge = trial >= {1'b0, base};
    rem_nxt  = trial_ge ? DW'(trial - {1'b0, base}) : trial[DW-1:0];
    mag_nxt  = {mag_r[W-2:0], trial_ge};
  end

  always_comb begin
    status.last_bit      = bit_cnt_r == sitra_pkg::BIT_LAST;
    status.quot_zero_nxt = mag_nxt == '0;
    status.neg           = neg_r;
    status.idx_zero      = idx_r == '0;
    status.out_free      = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= sitra_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r <= '0;
      count_r   <= '0;
      idx_r     <= '0;
      neg_r     <= 1'b0;
    end else if (cmd.load) begin
      bit_cnt_r <= '0;
      count_r   <= '0;
      neg_r     <= in_value[W-1];
    end else if (cmd.div_step) begin
      if (status.last_bit) begin
        bit_cnt_r <= '0;
        count_r   <= count_r + 1'b1;
        idx_r     <= count_r;
      end else begin
        bit_cnt_r <= bit_cnt_r + 1'b1;
      end
    end else if (cmd.emit_digit && !status.idx_zero) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= in_value[W-1] ? W'(-in_value) : W'(in_value);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      mag_r <= mag_nxt;
      // clear the remainder for the next division
      rem_r <= status.last_bit ? '0 : rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && status.last_bit) begin
      digit_store[count_r] <= rem_nxt;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= digit_store[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_r <= sitra_pkg::CHAR_MINUS;
      last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_r <= sitra_pkg::digit_char(rd_data_r);
      last_r <= status.idx_zero;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

endmodule

// ----- rtl/signed_int_to_radix_ascii.sv -----
// Signed integer to radix text converter, top level.
// Flow: accept the integer, then the bit-serial divider (one quotient bit a cycle) yields each
// digit, an optional sign word follows, then each digit word is read back and sent for output.
// Worst case is base 2 with 32 digits; one integer in flight at once, taken once the last word
// is loaded for output.
// Reset (rst_n low, synchronous) idles the controller, empties the output, sets radix to 10.
module signed_int_to_radix_ascii (
  input  logic                           clk,
  input  logic                           rst_n,
  sitra_in_if.sink                       in_ch,
  sitra_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [sitra_pkg::RADIX_W-1:0]  cfg_data
);

  sitra_pkg::cmd_t    cmd;
  sitra_pkg::status_t status;

  sitra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  sitra_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_last      (out_ch.last)
  );

  assign in_ch.ready = cmd.in_ready;

endmodule
